[rtl/core/b2da_pkg.sv]
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and the double-dabble step for the decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int BinW          = 32;              // input number width
    localparam int DigitN        = 10;              // max decimal digits
    localparam int BcdW          = 4 * DigitN;      // packed BCD width
    localparam int DdW           = BcdW + BinW;     // BCD + binary shift word
    localparam int StageN        = 4;               // pipeline stages
    localparam int StepsPerStage = BinW / StageN;   // bits shifted per stage
    localparam int DigIdxW       = $clog2(DigitN);  // digit index width
    localparam int CharW         = 6;               // ASCII digit code width
    localparam int OutDataW      = 8;               // output tdata width

    localparam logic [CharW-1:0] AsciiZero = 6'd48;

    // One shift-and-add-3 step: correct each BCD nibble, then shift left.
    function automatic logic [DdW-1:0] dd_step(input logic [DdW-1:0] x);
        logic [DdW-1:0] y;
        y = x;
        for (int i = 0; i < DigitN; i++) begin
            if (y[BinW + 4*i +: 4] >= 4'd5) begin
                y[BinW + 4*i +: 4] = y[BinW + 4*i +: 4] + 4'd3;
            end
        end
        return {y[DdW-2:0], 1'b0};
    endfunction

endpackage

[rtl/core/binary_to_decimal_ascii_digits.sv]
// The first digit is offered once the number has passed the 4 double-dabble
// stages in order and has then been loaded into the serializer's digit
// register. Throughput: one digit per cycle while the output is ready; a
// number sends 1 to 10 digits, set by its digit count; the stages take a new
// number every cycle unless back-pressure holds them.
// Reset: synchronous, active low; clears all valid flags, numbers in flight are dropped.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_digits
// Streams a 32-bit unsigned number out as ASCII decimal digits, no leading
// zeros, MSD first, tlast on the units digit.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_digits
    import b2da_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [BinW-1:0]     i_s_tdata,   // [31:0] number
    // output stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [OutDataW-1:0] o_m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                o_m_tlast    // last_digit
);

    // Chain of handshakes through the conversion stages. Entry k feeds
    // stage k; entry StageN feeds the serializer.
    logic [StageN:0] w_valid;
    logic [StageN:0] w_ready;
    logic [DdW-1:0]  w_data [StageN+1];

    // Shift word: BCD accumulator in the upper bits, binary in the lower.
    assign w_valid[0] = i_s_tvalid;
    assign w_data[0]  = {{BcdW{1'b0}}, i_s_tdata};
    assign o_s_tready = w_ready[0];

    // Each stage runs StepsPerStage shift-add-3 steps and registers; a stage
    // takes a new word when it is empty or its content moves on this cycle.
    for (genvar g = 0; g < StageN; g++) begin : g_stage
        b2da_dd_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    // After all 32 shifts the upper bits hold ten packed BCD digits. The
    // serializer loads them and walks down from the leading nonzero digit;
    // it reloads in the same cycle the last digit transfers.
    b2da_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[StageN]),
        .o_ready (w_ready[StageN]),
        .i_bcd   (w_data[StageN][DdW-1:BinW]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

endmodule

[rtl/core/b2da_dd_stage.sv]
// ----------------------------------------------------------------------------
// b2da_dd_stage
// One registered double-dabble stage: StepsPerStage shift-add-3 steps.
// ----------------------------------------------------------------------------
module b2da_dd_stage
    import b2da_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [DdW-1:0] i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [DdW-1:0] o_data
);

    logic           r_valid;
    logic [DdW-1:0] r_data;
    logic [DdW-1:0] n_data;

    always_comb begin
        n_data = i_data;
        for (int s = 0; s < StepsPerStage; s++) begin
            n_data = dd_step(n_data);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/core/b2da_serializer.sv]
// ----------------------------------------------------------------------------
// b2da_serializer
// Holds one BCD number and sends its digits, most significant first.
// ----------------------------------------------------------------------------
module b2da_serializer
    import b2da_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [BcdW-1:0]     i_bcd,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [OutDataW-1:0] o_data,
    output logic                o_last
);

    logic               r_busy;
    logic [BcdW-1:0]    r_bcd;
    logic [DigIdxW-1:0] r_idx;
    logic [DigIdxW-1:0] n_idx;
    logic [3:0]         w_digit;
    logic               w_done;

    // Index of the highest nonzero digit; zero keeps the single units digit.
    always_comb begin
        n_idx = '0;
        for (int i = 0; i < DigitN; i++) begin
            if (i_bcd[4*i +: 4] != 4'd0) begin
                n_idx = DigIdxW'(i);
            end
        end
    end

    assign w_done  = i_ready && (r_idx == '0);
    assign o_ready = !r_busy || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_ready) begin
            r_busy <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bcd <= i_bcd;
            r_idx <= n_idx;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    assign w_digit = r_bcd[4*r_idx +: 4];
    assign o_valid = r_busy;
    assign o_last  = (r_idx == '0);
    assign o_data  = {{(OutDataW-CharW){1'b0}}, AsciiZero + {2'b00, w_digit}};

endmodule
